@@ hdl/cso_pkg.sv @@
package cso_pkg;

  // Fixed field widths.
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned MINP_W     = 16;
  localparam int unsigned TOL_W      = 32;
  localparam int unsigned PKT_W      = 32;

  // Configuration write channel.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_HOST_ID       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PACKETS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 8'd3;

  localparam logic [ID_W-1:0]       HOST_ID_RST       = 8'd0;
  localparam logic [INTERVAL_W-1:0] SEND_INTERVAL_RST = 16'd6;
  localparam logic [MINP_W-1:0]     MIN_PACKETS_RST   = 16'd0;
  localparam logic [TOL_W-1:0]      TOLERANCE_RST     = 32'd65536;

  // Frame number that marks "no request sent yet".
  localparam logic [FRAME_W-1:0] NEVER_SENT = 16'hFFFF;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

endpackage

@@ hdl/cso_item_if.sv @@
interface cso_item_if #(
  parameter int unsigned TIME_WIDTH = 32
);
  import cso_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FRAME_W-1:0]    frame_num;
  logic [TIME_WIDTH-1:0] global_time;
  logic [TIME_WIDTH-1:0] network_time;
  logic                  local_valid;
  logic [ID_W-1:0]       local_player_id;
  logic                  host_connected;
  logic                  msg_valid;
  logic [ID_W-1:0]       msg_client_id;
  logic [ID_W-1:0]       msg_host_id;
  logic [TIME_WIDTH-1:0] msg_client_time;
  logic [TIME_WIDTH-1:0] msg_host_time;

  modport source (
    output valid, frame_num, global_time, network_time, local_valid, local_player_id,
           host_connected, msg_valid, msg_client_id, msg_host_id, msg_client_time,
           msg_host_time,
    input  ready
  );

  modport sink (
    input  valid, frame_num, global_time, network_time, local_valid, local_player_id,
           host_connected, msg_valid, msg_client_id, msg_host_id, msg_client_time,
           msg_host_time,
    output ready
  );

endinterface

@@ hdl/cso_result_if.sv @@
interface cso_result_if #(
  parameter int unsigned TIME_WIDTH = 32
);
  import cso_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] network_time_out;
  logic                  time_written;
  logic                  send_request;
  logic [FRAME_W-1:0]    send_frame;
  logic [TIME_WIDTH-1:0] send_client_time;
  logic [ID_W-1:0]       send_client_id;
  logic                  synchronised;
  logic [PKT_W-1:0]      packets_received;

  modport source (
    output valid, network_time_out, time_written, send_request, send_frame,
           send_client_time, send_client_id, synchronised, packets_received,
    input  ready
  );

  modport sink (
    input  valid, network_time_out, time_written, send_request, send_frame,
           send_client_time, send_client_id, synchronised, packets_received,
    output ready
  );

endinterface

@@ hdl/cso_cfg_if.sv @@
interface cso_cfg_if;
  import cso_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );

endinterface

@@ hdl/cso_alu.sv @@
module cso_alu #(
  parameter int unsigned ALU_W = 36
) (
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  input  cso_pkg::alu_op_e op_i,
  output logic [ALU_W-1:0] res_o
);
  import cso_pkg::*;

  // Shared adder. Operands arrive already extended, so the top bit of the
  // result is the sign of a signed result or the borrow of an unsigned one.
  always_comb begin
    case (op_i)
      ALU_ADD: res_o = a_i + b_i;
      ALU_SUB: res_o = a_i - b_i;
      default: res_o = a_i + b_i;
    endcase
  end

endmodule

@@ hdl/cso_div.sv @@
module cso_div #(
  parameter int unsigned DVD_W = 35,
  parameter int unsigned DVS_W = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);
  import cso_pkg::*;

  // Restoring division, four quotient bits per cycle, msb first.
  localparam int unsigned DIGITS = 4;
  localparam int unsigned DIV_W  = ((DVD_W + DIGITS - 1) / DIGITS) * DIGITS;
  localparam int unsigned STEPS  = DIV_W / DIGITS;
  localparam int unsigned SC_W   = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [DIV_W-1:0] work_q, work_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [SC_W-1:0]  step_q, step_d;
  logic             busy_q, busy_d;

  always_comb begin
    logic [DVS_W:0]   trial;
    logic [DVS_W-1:0] rem;
    logic [DIV_W-1:0] work;
    logic             qbit;

    trial  = '0;
    qbit   = 1'b0;
    rem    = rem_q;
    work   = work_q;
    work_d = work_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;

    if (start_i) begin
      work_d = {{(DIV_W-DVD_W){1'b0}}, dividend_i};
      rem_d  = '0;
      dvs_d  = divisor_i;
      step_d = SC_W'(STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int k = 0; k < DIGITS; k++) begin
        trial = {rem, work[DIV_W-1]};
        if (trial >= {1'b0, dvs_q}) begin
          rem  = DVS_W'(trial - {1'b0, dvs_q});
          qbit = 1'b1;
        end else begin
          rem  = trial[DVS_W-1:0];
          qbit = 1'b0;
        end
        work = {work[DIV_W-2:0], qbit};
      end
      work_d = work;
      rem_d  = rem;
      if (step_q == '0) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = work_q[DVD_W-1:0];

endmodule

@@ hdl/clock_sync_offset_estimator.sv @@
// Channel   Modport  Accepted when           Carries
// item_i    sink     valid && ready          one frame update with optional sync reply
// result_o  source   valid && ready          network time, send request, sync status
// cfg_i     sink     valid && ready (ready=1) register index and write data
//
// A frame without a matching reply goes from the check to the output state when no
// offset is stored or too few packets have arrived. Otherwise the shared adder walks
// the window once per sum and the divider forms each average. item_i is not ready
// while a frame is in work. A finished result waits in the output register, and the
// next frame is taken meanwhile. Reset sets all state at once, with no clearing pass.
module clock_sync_offset_estimator #(
  parameter int unsigned WINDOW_DEPTH = 4,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cso_item_if.sink     item_i,
  cso_result_if.source result_o,
  cso_cfg_if.sink      cfg_i
);
  import cso_pkg::*;

  localparam int unsigned TW     = TIME_WIDTH;
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned ACC_W  = TW + $clog2(WINDOW_DEPTH) + 1;
  localparam int unsigned ALU_W  = ((ACC_W > TOL_W) ? ACC_W : TOL_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELAY,
    S_DSUM,
    S_DWAIT,
    S_EST,
    S_OFFS,
    S_CHECK,
    S_OSUM,
    S_ABS,
    S_OWAIT,
    S_TOL,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  // Configuration.
  logic [ID_W-1:0]       host_id_q, host_id_d;
  logic [INTERVAL_W-1:0] interval_q, interval_d;
  logic [MINP_W-1:0]     min_pkt_q, min_pkt_d;
  logic [TOL_W-1:0]      tol_q, tol_d;

  // Windows. Both rings advance together, so one head and one count serve both.
  logic [TW-1:0] delay_ring_q [WINDOW_DEPTH];
  logic [TW-1:0] delay_ring_d [WINDOW_DEPTH];
  logic [TW:0]   offs_ring_q  [WINDOW_DEPTH];
  logic [TW:0]   offs_ring_d  [WINDOW_DEPTH];
  logic [HEAD_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PKT_W-1:0]  pkt_q, pkt_d;
  logic [FRAME_W-1:0] last_sent_q, last_sent_d;

  // Captured frame.
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [TW-1:0]      now_q, now_d;
  logic [TW-1:0]      net_in_q, net_in_d;
  logic [TW-1:0]      ctime_q, ctime_d;
  logic [TW-1:0]      htime_q, htime_d;
  logic [ID_W-1:0]    lid_q, lid_d;
  logic               match_q, match_d;
  logic               send_q, send_d;

  // Working registers.
  logic [ALU_W-1:0]  acc_q, acc_d;
  logic [HEAD_W-1:0] idx_q, idx_d;
  logic [TW-1:0]     est_q, est_d;
  logic              sync_q, sync_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [TW-1:0]      o_net_q, o_net_d;
  logic               o_written_q, o_written_d;
  logic               o_send_q, o_send_d;
  logic [FRAME_W-1:0] o_frame_q, o_frame_d;
  logic [TW-1:0]      o_ctime_q, o_ctime_d;
  logic [ID_W-1:0]    o_cid_q, o_cid_d;
  logic               o_sync_q, o_sync_d;
  logic [PKT_W-1:0]   o_pkt_q, o_pkt_d;

  // Shared units.
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  alu_op_e          alu_op;
  logic             div_start, div_busy;
  logic [ACC_W-1:0] div_quo;

  logic [FRAME_W-1:0] frame_diff;
  logic               idx_last;
  logic [HEAD_W-1:0]  head_next;
  logic [CNT_W-1:0]   count_next;

  cso_alu #(
    .ALU_W (ALU_W)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  cso_div #(
    .DVD_W (ACC_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (alu_res[ACC_W-1:0]),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign frame_diff = item_i.frame_num - last_sent_q;
  assign idx_last   = ({{(CNT_W-HEAD_W){1'b0}}, idx_q} == (count_q - 1'b1));
  assign head_next  = (head_q == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign count_next = (count_q == CNT_W'(WINDOW_DEPTH)) ? count_q : count_q + 1'b1;

  assign item_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;

  always_comb begin
    state_d      = state_q;
    host_id_d    = host_id_q;
    interval_d   = interval_q;
    min_pkt_d    = min_pkt_q;
    tol_d        = tol_q;
    delay_ring_d = delay_ring_q;
    offs_ring_d  = offs_ring_q;
    head_d       = head_q;
    count_d      = count_q;
    pkt_d        = pkt_q;
    last_sent_d  = last_sent_q;
    frame_d      = frame_q;
    now_d        = now_q;
    net_in_d     = net_in_q;
    ctime_d      = ctime_q;
    htime_d      = htime_q;
    lid_d        = lid_q;
    match_d      = match_q;
    send_d       = send_q;
    acc_d        = acc_q;
    idx_d        = idx_q;
    est_d        = est_q;
    sync_d       = sync_q;
    out_valid_d  = out_valid_q;
    o_net_d      = o_net_q;
    o_written_d  = o_written_q;
    o_send_d     = o_send_q;
    o_frame_d    = o_frame_q;
    o_ctime_d    = o_ctime_q;
    o_cid_d      = o_cid_q;
    o_sync_d     = o_sync_q;
    o_pkt_d      = o_pkt_q;
    alu_op       = ALU_ADD;
    alu_a        = '0;
    alu_b        = '0;
    div_start    = 1'b0;

    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_HOST_ID:       host_id_d  = cfg_i.data[ID_W-1:0];
        CFG_SEND_INTERVAL: interval_d = cfg_i.data[INTERVAL_W-1:0];
        CFG_MIN_PACKETS:   min_pkt_d  = cfg_i.data[MINP_W-1:0];
        CFG_TOLERANCE:     tol_d      = cfg_i.data[TOL_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (item_i.valid) begin
          frame_d  = item_i.frame_num;
          now_d    = item_i.global_time;
          net_in_d = item_i.network_time;
          ctime_d  = item_i.msg_client_time;
          htime_d  = item_i.msg_host_time;
          lid_d    = item_i.local_player_id;
          match_d  = item_i.local_valid && item_i.msg_valid &&
                     (item_i.msg_client_id == item_i.local_player_id) &&
                     (item_i.msg_host_id == host_id_q);
          send_d   = item_i.local_valid && item_i.host_connected &&
                     ((last_sent_q == NEVER_SENT) || (frame_diff >= interval_q));
          if (item_i.local_valid && item_i.host_connected &&
              ((last_sent_q == NEVER_SENT) || (frame_diff >= interval_q))) begin
            last_sent_d = item_i.frame_num;
          end
          state_d = match_d ? S_DELAY : S_CHECK;
        end
      end
      S_DELAY: begin
        // Round trip, clamped at zero when the echoed stamp is in the future.
        alu_op = ALU_SUB;
        alu_a  = {{(ALU_W-TW){1'b0}}, now_q};
        alu_b  = {{(ALU_W-TW){1'b0}}, ctime_q};
        delay_ring_d[head_q] = alu_res[ALU_W-1] ? '0 : alu_res[TW-1:0];
        count_d = count_next;
        pkt_d   = (pkt_q == '1) ? pkt_q : pkt_q + PKT_W'(1);
        acc_d   = '0;
        idx_d   = '0;
        state_d = S_DSUM;
      end
      S_DSUM: begin
        alu_op = ALU_ADD;
        alu_a  = acc_q;
        alu_b  = {{(ALU_W-TW){1'b0}}, delay_ring_q[idx_q]};
        acc_d  = alu_res;
        idx_d  = idx_q + 1'b1;
        if (idx_last) begin
          div_start = 1'b1;
          state_d   = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (!div_busy) begin
          state_d = S_EST;
        end
      end
      S_EST: begin
        alu_op = ALU_ADD;
        alu_a  = {{(ALU_W-TW){1'b0}}, htime_q};
        alu_b  = {{(ALU_W-TW){1'b0}}, div_quo[TW:1]};
        est_d  = (|alu_res[ALU_W-1:TW]) ? '1 : alu_res[TW-1:0];
        state_d = S_OFFS;
      end
      S_OFFS: begin
        alu_op = ALU_SUB;
        alu_a  = {{(ALU_W-TW){1'b0}}, net_in_q};
        alu_b  = {{(ALU_W-TW){1'b0}}, est_q};
        offs_ring_d[head_q] = alu_res[TW:0];
        head_d  = head_next;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // A borrow here means fewer packets than min_packets.
        alu_op = ALU_SUB;
        alu_a  = {{(ALU_W-PKT_W){1'b0}}, pkt_q};
        alu_b  = {{(ALU_W-MINP_W){1'b0}}, min_pkt_q};
        if ((count_q == '0) || alu_res[ALU_W-1]) begin
          sync_d  = 1'b0;
          state_d = S_OUT;
        end else begin
          acc_d   = '0;
          idx_d   = '0;
          state_d = S_OSUM;
        end
      end
      S_OSUM: begin
        alu_op = ALU_ADD;
        alu_a  = acc_q;
        alu_b  = {{(ALU_W-TW-1){offs_ring_q[idx_q][TW]}}, offs_ring_q[idx_q]};
        acc_d  = alu_res;
        idx_d  = idx_q + 1'b1;
        if (idx_last) begin
          state_d = S_ABS;
        end
      end
      S_ABS: begin
        // Dividing the magnitude truncates the signed average toward zero.
        if (acc_q[ALU_W-1]) begin
          alu_op = ALU_SUB;
          alu_a  = '0;
          alu_b  = acc_q;
        end else begin
          alu_op = ALU_ADD;
          alu_a  = acc_q;
          alu_b  = '0;
        end
        div_start = 1'b1;
        state_d   = S_OWAIT;
      end
      S_OWAIT: begin
        if (!div_busy) begin
          state_d = S_TOL;
        end
      end
      S_TOL: begin
        alu_op  = ALU_SUB;
        alu_a   = {{(ALU_W-TOL_W){1'b0}}, tol_q};
        alu_b   = {{(ALU_W-ACC_W){1'b0}}, div_quo};
        sync_d  = !alu_res[ALU_W-1];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          o_net_d     = match_q ? est_q : net_in_q;
          o_written_d = match_q;
          o_send_d    = send_q;
          o_frame_d   = send_q ? frame_q : '0;
          o_ctime_d   = send_q ? now_q : '0;
          o_cid_d     = send_q ? lid_q : '0;
          o_sync_d    = sync_q;
          o_pkt_d     = pkt_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      host_id_q   <= HOST_ID_RST;
      interval_q  <= SEND_INTERVAL_RST;
      min_pkt_q   <= MIN_PACKETS_RST;
      tol_q       <= TOLERANCE_RST;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        delay_ring_q[i] <= '0;
        offs_ring_q[i]  <= {1'b0, {TW{1'b1}}};
      end
      head_q      <= '0;
      count_q     <= '0;
      pkt_q       <= '0;
      last_sent_q <= NEVER_SENT;
      frame_q     <= '0;
      now_q       <= '0;
      net_in_q    <= '0;
      ctime_q     <= '0;
      htime_q     <= '0;
      lid_q       <= '0;
      match_q     <= 1'b0;
      send_q      <= 1'b0;
      acc_q       <= '0;
      idx_q       <= '0;
      est_q       <= '0;
      sync_q      <= 1'b0;
      out_valid_q <= 1'b0;
      o_net_q     <= '0;
      o_written_q <= 1'b0;
      o_send_q    <= 1'b0;
      o_frame_q   <= '0;
      o_ctime_q   <= '0;
      o_cid_q     <= '0;
      o_sync_q    <= 1'b0;
      o_pkt_q     <= '0;
    end else begin
      state_q      <= state_d;
      host_id_q    <= host_id_d;
      interval_q   <= interval_d;
      min_pkt_q    <= min_pkt_d;
      tol_q        <= tol_d;
      delay_ring_q <= delay_ring_d;
      offs_ring_q  <= offs_ring_d;
      head_q       <= head_d;
      count_q      <= count_d;
      pkt_q        <= pkt_d;
      last_sent_q  <= last_sent_d;
      frame_q      <= frame_d;
      now_q        <= now_d;
      net_in_q     <= net_in_d;
      ctime_q      <= ctime_d;
      htime_q      <= htime_d;
      lid_q        <= lid_d;
      match_q      <= match_d;
      send_q       <= send_d;
      acc_q        <= acc_d;
      idx_q        <= idx_d;
      est_q        <= est_d;
      sync_q       <= sync_d;
      out_valid_q  <= out_valid_d;
      o_net_q      <= o_net_d;
      o_written_q  <= o_written_d;
      o_send_q     <= o_send_d;
      o_frame_q    <= o_frame_d;
      o_ctime_q    <= o_ctime_d;
      o_cid_q      <= o_cid_d;
      o_sync_q     <= o_sync_d;
      o_pkt_q      <= o_pkt_d;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.network_time_out = o_net_q;
  assign result_o.time_written     = o_written_q;
  assign result_o.send_request     = o_send_q;
  assign result_o.send_frame       = o_frame_q;
  assign result_o.send_client_time = o_ctime_q;
  assign result_o.send_client_id   = o_cid_q;
  assign result_o.synchronised     = o_sync_q;
  assign result_o.packets_received = o_pkt_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while still busy");

  a_div_busy_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_DWAIT || state_q == S_OWAIT))
    else $error("divider busy outside a wait state");

  a_pkt_only_on_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DELAY) |=> $stable(pkt_q))
    else $error("packet count changed without an accepted reply");

  a_written_has_packets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_written_q) |-> (o_pkt_q != '0 && count_q != '0))
    else $error("network time written with no packet counted");

endmodule

@@ tb/clock_sync_offset_estimator_test.sv @@
`timescale 1ns / 1ps

module clock_sync_offset_estimator_test;
  import cso_pkg::*;

  localparam int unsigned TW             = 32;
  localparam int unsigned WINDOW         = 4;
  localparam int          NUM_PHASES     = 8;
  localparam int          FRAMES_PER_SET = 66;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          LONG_HOLD      = 400;
  localparam int          SETTLE_CYCLES  = 50;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_num;
    logic [TW-1:0]      global_time;
    logic [TW-1:0]      network_time;
    logic               local_valid;
    logic [ID_W-1:0]    local_player_id;
    logic               host_connected;
    logic               msg_valid;
    logic [ID_W-1:0]    msg_client_id;
    logic [ID_W-1:0]    msg_host_id;
    logic [TW-1:0]      msg_client_time;
    logic [TW-1:0]      msg_host_time;
  } frame_t;

  typedef struct packed {
    logic [TW-1:0]      network_time_out;
    logic               time_written;
    logic               send_request;
    logic [FRAME_W-1:0] send_frame;
    logic [TW-1:0]      send_client_time;
    logic [ID_W-1:0]    send_client_id;
    logic               synchronised;
    logic [PKT_W-1:0]   packets_received;
  } sync_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cso_item_if #(.TIME_WIDTH(TW)) frame_ch ();
  cso_result_if #(.TIME_WIDTH(TW)) result_ch ();
  cso_cfg_if cfg_ch ();

  clock_sync_offset_estimator #(
    .WINDOW_DEPTH(WINDOW),
    .TIME_WIDTH  (TW)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (frame_ch),
    .result_o(result_ch),
    .cfg_i   (cfg_ch)
  );

  always #10 clk_i = ~clk_i;

  // Estimator state and registers as the block should hold them.
  logic [ID_W-1:0]       host_id_q;
  logic [INTERVAL_W-1:0] send_interval_q;
  logic [MINP_W-1:0]     min_packets_q;
  logic [TOL_W-1:0]      tolerance_q;
  logic [TW-1:0]         delay_ring [WINDOW];
  int                    delay_head;
  int                    delay_count;
  longint                offset_ring [WINDOW];
  int                    offset_head;
  int                    offset_count;
  logic [PKT_W-1:0]      packet_count;
  logic [FRAME_W-1:0]    last_sent_frame;

  frame_t       frames_to_send [$];
  sync_result_t expected_results [$];
  frame_t       on_wire;
  int           frames_queued;
  int           frames_taken;
  int           results_seen;
  int           mismatches;
  int           tx_gap;
  int           rx_stall;
  int           rx_hold;
  int           idle_cycles;
  bit           quiet;

  // Stimulus generator state: a plausible local clock and frame counter.
  logic [TW-1:0]      sim_clock;
  logic [TW-1:0]      clock_skew;
  logic [FRAME_W-1:0] frame_ctr;
  logic [ID_W-1:0]    local_id;

  function automatic sync_result_t advance_estimator(frame_t f);
    sync_result_t r;
    longint       dsum;
    longint       half;
    longint       est_l;
    logic [TW-1:0] est;
    logic [FRAME_W-1:0] since;
    longint       osum;
    longint       oavg;
    r = '0;
    r.network_time_out = f.network_time;
    if (f.local_valid) begin
      if (f.msg_valid && f.msg_client_id == f.local_player_id && f.msg_host_id == host_id_q) begin
        delay_ring[delay_head] = (f.global_time >= f.msg_client_time) ?
                                 f.global_time - f.msg_client_time : '0;
        delay_head = (delay_head + 1) % WINDOW;
        if (delay_count < WINDOW) delay_count++;
        if (packet_count != '1) packet_count++;
        dsum = 0;
        for (int i = 0; i < delay_count; i++) dsum += longint'(delay_ring[i]);
        half = (dsum / delay_count) / 2;
        est_l = longint'(f.msg_host_time) + half;
        est = (est_l > 64'h0000_0000_FFFF_FFFF) ? '1 : est_l[TW-1:0];
        offset_ring[offset_head] = longint'(f.network_time) - longint'(est);
        offset_head = (offset_head + 1) % WINDOW;
        if (offset_count < WINDOW) offset_count++;
        r.network_time_out = est;
        r.time_written = 1'b1;
      end
      if (f.host_connected) begin
        since = f.frame_num - last_sent_frame;
        if (last_sent_frame == NEVER_SENT || since >= send_interval_q) begin
          last_sent_frame = f.frame_num;
          r.send_request = 1'b1;
          r.send_frame = f.frame_num;
          r.send_client_time = f.global_time;
          r.send_client_id = f.local_player_id;
        end
      end
    end
    if (packet_count >= min_packets_q && offset_count != 0) begin
      osum = 0;
      for (int i = 0; i < offset_count; i++) osum += offset_ring[i];
      oavg = osum / offset_count;
      if (oavg < 0) oavg = -oavg;
      r.synchronised = (oavg <= longint'(tolerance_q));
    end
    r.packets_received = packet_count;
    return r;
  endfunction

  function automatic frame_t directed_frame(
    logic [FRAME_W-1:0] frame, logic [TW-1:0] now, logic [TW-1:0] net,
    logic lv, logic [ID_W-1:0] lid, logic conn, logic mv,
    logic [ID_W-1:0] mcid, logic [ID_W-1:0] mhid, logic [TW-1:0] mct, logic [TW-1:0] mht);
    frame_t f;
    f.frame_num       = frame;
    f.global_time     = now;
    f.network_time    = net;
    f.local_valid     = lv;
    f.local_player_id = lid;
    f.host_connected  = conn;
    f.msg_valid       = mv;
    f.msg_client_id   = mcid;
    f.msg_host_id     = mhid;
    f.msg_client_time = mct;
    f.msg_host_time   = mht;
    return f;
  endfunction

  function automatic frame_t next_frame();
    frame_t      f;
    logic [255:0] noise;
    int unsigned rtt;
    int          jitter;
    if ($urandom_range(0, 3) == 0) begin
      noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom()};
      f = noise[$bits(frame_t)-1:0];
      // Half the noise frames still carry a matching reply with arbitrary stamps.
      if ($urandom_range(0, 1) == 0) begin
        f.local_valid   = 1'b1;
        f.msg_valid     = 1'b1;
        f.msg_client_id = f.local_player_id;
        f.msg_host_id   = host_id_q;
      end
    end else begin
      frame_ctr += ($urandom_range(0, 9) == 0) ? 16'($urandom_range(2, 300)) : 16'd1;
      sim_clock += $urandom_range(500, 3000);
      rtt = $urandom_range(0, 40000);
      jitter = $urandom_range(0, 262144);
      jitter = jitter - 131072;
      f.frame_num       = frame_ctr;
      f.global_time     = sim_clock;
      f.network_time    = sim_clock + clock_skew + jitter;
      f.local_valid     = ($urandom_range(0, 19) != 0);
      f.local_player_id = local_id;
      f.host_connected  = ($urandom_range(0, 7) != 0);
      f.msg_valid       = ($urandom_range(0, 1) == 0);
      f.msg_client_id   = ($urandom_range(0, 9) == 0) ? ID_W'($urandom()) : local_id;
      f.msg_host_id     = ($urandom_range(0, 9) == 0) ? ID_W'($urandom()) : host_id_q;
      f.msg_client_time = sim_clock - rtt;
      if ($urandom_range(0, 19) == 0) f.msg_client_time = sim_clock + $urandom_range(1, 5000);
      f.msg_host_time   = f.msg_client_time + rtt / 2 + clock_skew;
      if ($urandom_range(0, 19) == 0) f.msg_host_time = '1 - $urandom_range(0, 30000);
    end
    return f;
  endfunction

  function automatic reg_write_t reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    reg_write_t w;
    w.index = idx;
    w.data  = d;
    return w;
  endfunction

  // Called right after a rising edge; valid stays high across back-to-back writes.
  task automatic write_regs(input reg_write_t writes [$]);
    foreach (writes[k]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= writes[k].index;
      cfg_ch.data  <= writes[k].data;
      do @(posedge clk_i); while (!cfg_ch.ready);
      case (writes[k].index)
        CFG_HOST_ID:       host_id_q       = writes[k].data[ID_W-1:0];
        CFG_SEND_INTERVAL: send_interval_q = writes[k].data[INTERVAL_W-1:0];
        CFG_MIN_PACKETS:   min_packets_q   = writes[k].data[MINP_W-1:0];
        CFG_TOLERANCE:     tolerance_q     = writes[k].data[TOL_W-1:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (frames_taken != frames_queued || expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_field(string name, logic [TW-1:0] want, logic [TW-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
    end
  endtask

  // Frame driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        expected_results.push_back(advance_estimator(on_wire));
        frames_taken++;
      end
      if (frame_ch.valid && !frame_ch.ready) begin
        // Hold the offered word until the block takes it.
      end else if (tx_gap > 0) begin
        tx_gap--;
        frame_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        tx_gap = $urandom_range(1, 19) - 1;
        frame_ch.valid <= 1'b0;
      end else if (frames_to_send.size() != 0) begin
        on_wire = frames_to_send.pop_front();
        frame_ch.valid           <= 1'b1;
        frame_ch.frame_num       <= on_wire.frame_num;
        frame_ch.global_time     <= on_wire.global_time;
        frame_ch.network_time    <= on_wire.network_time;
        frame_ch.local_valid     <= on_wire.local_valid;
        frame_ch.local_player_id <= on_wire.local_player_id;
        frame_ch.host_connected  <= on_wire.host_connected;
        frame_ch.msg_valid       <= on_wire.msg_valid;
        frame_ch.msg_client_id   <= on_wire.msg_client_id;
        frame_ch.msg_host_id     <= on_wire.msg_host_id;
        frame_ch.msg_client_time <= on_wire.msg_client_time;
        frame_ch.msg_host_time   <= on_wire.msg_host_time;
      end else begin
        frame_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    sync_result_t got;
    sync_result_t want;
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.network_time_out = result_ch.network_time_out;
        got.time_written     = result_ch.time_written;
        got.send_request     = result_ch.send_request;
        got.send_frame       = result_ch.send_frame;
        got.send_client_time = result_ch.send_client_time;
        got.send_client_id   = result_ch.send_client_id;
        got.synchronised     = result_ch.synchronised;
        got.packets_received = result_ch.packets_received;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with no frame outstanding", results_seen);
        end else begin
          want = expected_results.pop_front();
          compare_field("network_time_out", want.network_time_out, got.network_time_out);
          compare_field("time_written", want.time_written, got.time_written);
          compare_field("send_request", want.send_request, got.send_request);
          compare_field("send_frame", want.send_frame, got.send_frame);
          compare_field("send_client_time", want.send_client_time, got.send_client_time);
          compare_field("send_client_id", want.send_client_id, got.send_client_id);
          compare_field("synchronised", want.synchronised, got.synchronised);
          compare_field("packets_received", want.packets_received, got.packets_received);
        end
        results_seen++;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        result_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        result_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(1, 19) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[clock_sync_offset_estimator] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [ID_W-1:0]       host;
    logic [INTERVAL_W-1:0] interval;
    logic [MINP_W-1:0]     minp;
    logic [TOL_W-1:0]      tol;
    logic [ID_W-1:0]       lid;
    reg_write_t            writes [$];

    rst_ni = 1'b0;
    frame_ch.valid = 1'b0;
    frame_ch.frame_num = '0;
    frame_ch.global_time = '0;
    frame_ch.network_time = '0;
    frame_ch.local_valid = 1'b0;
    frame_ch.local_player_id = '0;
    frame_ch.host_connected = 1'b0;
    frame_ch.msg_valid = 1'b0;
    frame_ch.msg_client_id = '0;
    frame_ch.msg_host_id = '0;
    frame_ch.msg_client_time = '0;
    frame_ch.msg_host_time = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    quiet = 1'b0;
    rx_hold = 0;
    idle_cycles = 0;
    frames_queued = 0;
    frames_taken = 0;
    results_seen = 0;
    mismatches = 0;

    host_id_q = HOST_ID_RST;
    send_interval_q = SEND_INTERVAL_RST;
    min_packets_q = MIN_PACKETS_RST;
    tolerance_q = TOLERANCE_RST;
    for (int i = 0; i < WINDOW; i++) begin
      delay_ring[i] = '0;
      offset_ring[i] = 64'h0000_0000_FFFF_FFFF;
    end
    delay_head = 0;
    delay_count = 0;
    offset_head = 0;
    offset_count = 0;
    packet_count = '0;
    last_sent_frame = NEVER_SENT;

    sim_clock = $urandom_range(0, 32'h7FFF_FFFF);
    frame_ctr = FRAME_W'($urandom());

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset register values (host id 0, interval 6).
    lid = 8'h5A;
    frames_to_send = '{
      // No local player: even a matching reply on a connected frame does nothing.
      directed_frame(16'd0, 32'h0010_0000, 32'h0011_0000, 1'b0, lid, 1'b1, 1'b1, lid, 8'h00,
                     32'h000F_0000, 32'h0010_0000),
      // First connected frame sends because nothing was sent yet; nothing stored.
      directed_frame(16'd0, 32'h0010_0000, 32'h0011_0000, 1'b1, lid, 1'b1, 1'b0, lid, 8'h00,
                     32'h0, 32'h0),
      directed_frame(16'd1, 32'h0011_0000, 32'h0011_0000, 1'b1, lid, 1'b1, 1'b0, lid, 8'h00,
                     32'h0, 32'h0),
      directed_frame(16'd6, 32'h0064_0000, 32'h0100_8000, 1'b1, lid, 1'b1, 1'b1, lid, 8'h00,
                     32'h0063_0000, 32'h0100_0000),
      // Reply stamped later than now.
      directed_frame(16'd7, 32'h0065_0000, 32'h0101_0000, 1'b1, lid, 1'b1, 1'b1, lid, 8'h00,
                     32'h0070_0000, 32'h0101_0000),
      directed_frame(16'd8, 32'h0066_0000, 32'h0102_0000, 1'b1, lid, 1'b1, 1'b1, 8'h5B, 8'h00,
                     32'h0065_0000, 32'h0102_0000),
      directed_frame(16'd9, 32'h0067_0000, 32'h0103_0000, 1'b1, lid, 1'b1, 1'b1, lid, 8'h01,
                     32'h0066_0000, 32'h0103_0000),
      // Host stamp near the top saturates the estimate.
      directed_frame(16'd10, 32'h0068_0000, 32'h0104_0000, 1'b1, lid, 1'b1, 1'b1, lid, 8'h00,
                     32'h0060_0000, 32'hFFFF_FFFF),
      directed_frame(16'd11, 32'h0069_0000, 32'h0000_0000, 1'b1, lid, 1'b1, 1'b1, lid, 8'h00,
                     32'h0068_0000, 32'h0200_0000),
      directed_frame(16'd12, 32'h006A_0000, 32'h0105_0000, 1'b1, lid, 1'b0, 1'b0, lid, 8'h00,
                     32'h0, 32'h0),
      // Sending on frame 0xFFFF leaves the block as if it never sent.
      directed_frame(16'hFFFF, 32'h006B_0000, 32'h0106_0000, 1'b1, lid, 1'b1, 1'b0, lid, 8'h00,
                     32'h0, 32'h0),
      directed_frame(16'hFFFF, 32'h006C_0000, 32'h0107_0000, 1'b1, lid, 1'b1, 1'b0, lid, 8'h00,
                     32'h0, 32'h0),
      directed_frame(16'd0, 32'h006D_0000, 32'h0108_0000, 1'b1, lid, 1'b1, 1'b0, lid, 8'h00,
                     32'h0, 32'h0),
      directed_frame(16'd0, 32'h0, 32'h0, 1'b1, 8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 32'h0, 32'h0),
      directed_frame(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF,
                     8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      // Four consistent replies fill the offset window with small offsets.
      directed_frame(16'd20, 32'h0200_0000, 32'h0300_1000, 1'b1, lid, 1'b1, 1'b1, lid, 8'h00,
                     32'h01FF_E000, 32'h0300_0000),
      directed_frame(16'd21, 32'h0201_0000, 32'h0301_1000, 1'b1, lid, 1'b1, 1'b1, lid, 8'h00,
                     32'h0200_E000, 32'h0301_0000),
      directed_frame(16'd22, 32'h0202_0000, 32'h0302_1000, 1'b1, lid, 1'b1, 1'b1, lid, 8'h00,
                     32'h0201_E000, 32'h0302_0000),
      directed_frame(16'd23, 32'h0203_0000, 32'h0303_1000, 1'b1, lid, 1'b1, 1'b1, lid, 8'h00,
                     32'h0202_E000, 32'h0303_0000)
    };
    frames_queued = frames_to_send.size();
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          host = 8'hFF; interval = 16'd0; minp = 16'd0; tol = 32'hFFFF_FFFF;
        end
        1: begin
          host = ID_W'($urandom()); interval = 16'hFFFF; minp = 16'hFFFF; tol = 32'd1;
        end
        2: begin
          host = 8'h00; interval = 16'd1; minp = 16'd2; tol = 32'd65536;
        end
        default: begin
          host = ID_W'($urandom());
          interval = INTERVAL_W'($urandom_range(1, 12));
          minp = MINP_W'($urandom_range(0, 6));
          tol = $urandom_range(1, 32'h0004_0000);
        end
      endcase
      writes = '{};
      writes.push_back(reg_write(CFG_HOST_ID, ($urandom() & 32'hFFFF_FF00) | host));
      writes.push_back(reg_write(CFG_SEND_INTERVAL, ($urandom() & 32'hFFFF_0000) | interval));
      writes.push_back(reg_write(CFG_MIN_PACKETS, ($urandom() & 32'hFFFF_0000) | minp));
      writes.push_back(reg_write(CFG_TOLERANCE, tol));
      // An index past the register list must leave every register alone.
      if (p == 0 || p == 4)
        writes.push_back(reg_write(CFG_IDX_W'($urandom_range(4, 255)), $urandom()));
      write_regs(writes);

      local_id = ID_W'($urandom());
      clock_skew = $urandom();
      quiet = (p == NUM_PHASES - 1);
      // The receiver holds off long enough for the block to back up onto its input.
      if (p == 2) rx_hold = LONG_HOLD;
      for (int n = 0; n < FRAMES_PER_SET; n++) begin
        frames_to_send.push_back(next_frame());
        frames_queued++;
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[clock_sync_offset_estimator] OK");
    end else begin
      $display("[clock_sync_offset_estimator] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/cso_pkg.sv
hdl/cso_item_if.sv
hdl/cso_result_if.sv
hdl/cso_cfg_if.sv
hdl/cso_alu.sv
hdl/cso_div.sv
hdl/clock_sync_offset_estimator.sv
tb/clock_sync_offset_estimator_test.sv
